[design/mbd_pkg.sv]
// Shared types, constants and the quad filter for the mip box downsampler.
// No dependencies; every other design file but mbd_ram uses this package.
package mbd_pkg;

  localparam int PIX_W       = 32;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int FMT_W       = 3;
  localparam int MAX_DIM_DEF = 2048;
  localparam int QUEUE_DEPTH = 4;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Channel masks
  localparam logic [7:0] M1 = 8'h01;
  localparam logic [7:0] M4 = 8'h0F;
  localparam logic [7:0] M5 = 8'h1F;
  localparam logic [7:0] M6 = 8'h3F;
  localparam logic [7:0] M8 = 8'hFF;

  typedef enum logic [FMT_W-1:0] {
    FMT_ARGB8888 = 3'd0,
    FMT_R5G6B5   = 3'd1,
    FMT_A4R4G4B4 = 3'd2,
    FMT_A1R5G5B5 = 3'd3,
    FMT_L8       = 3'd4
  } fmt_t;

  // Word handed from the front to the queue stage
  typedef struct packed {
    logic             h1;    // parent height of one: no line buffer read
    logic             last;  // closes the level
    logic [PIX_W-1:0] left;  // bottom-left sample
    logic [PIX_W-1:0] px;    // bottom-right sample
  } stage_t;

  // One full quad waiting for the filter
  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
    logic             last;
  } q_entry_t;

  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    logic [9:0] s;
    s = 10'(a) + 10'(b) + 10'(c) + 10'(d) + 10'd2;
    return s[9:2];
  endfunction

  function automatic logic [7:0] avg_ch(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                        input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d,
                                        input logic [4:0] sh, input logic [7:0] m);
    logic [7:0] r;
    r = avg8(8'(a >> sh) & m, 8'(b >> sh) & m, 8'(c >> sh) & m, 8'(d >> sh) & m);
    return r & m;
  endfunction

  function automatic logic [PIX_W-1:0] place(input logic [7:0] v, input logic [4:0] sh);
    return PIX_W'(v) << sh;
  endfunction

  function automatic logic [PIX_W-1:0] quad_filter(input fmt_t f,
      input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
      input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] res;
    logic [2:0]       ones;
    ones = 3'(a[15]) + 3'(b[15]) + 3'(c[15]) + 3'(d[15]);
    case (f)
      FMT_R5G6B5: begin
        res = place(avg_ch(a, b, c, d, 5'd11, M5), 5'd11)
            | place(avg_ch(a, b, c, d, 5'd5, M6), 5'd5)
            | place(avg_ch(a, b, c, d, 5'd0, M5), 5'd0);
      end
      FMT_A4R4G4B4: begin
        res = place(avg_ch(a, b, c, d, 5'd12, M4), 5'd12)
            | place(avg_ch(a, b, c, d, 5'd8, M4), 5'd8)
            | place(avg_ch(a, b, c, d, 5'd4, M4), 5'd4)
            | place(avg_ch(a, b, c, d, 5'd0, M4), 5'd0);
      end
      FMT_A1R5G5B5: begin
        // alpha is a majority vote: two of four set bits win
        res = place((ones >= 3'd2) ? M1 : 8'h00, 5'd15)
            | place(avg_ch(a, b, c, d, 5'd10, M5), 5'd10)
            | place(avg_ch(a, b, c, d, 5'd5, M5), 5'd5)
            | place(avg_ch(a, b, c, d, 5'd0, M5), 5'd0);
      end
      FMT_L8: begin
        res = place(avg_ch(a, b, c, d, 5'd0, M8), 5'd0);
      end
      default: begin
        res = place(avg_ch(a, b, c, d, 5'd24, M8), 5'd24)
            | place(avg_ch(a, b, c, d, 5'd16, M8), 5'd16)
            | place(avg_ch(a, b, c, d, 5'd8, M8), 5'd8)
            | place(avg_ch(a, b, c, d, 5'd0, M8), 5'd0);
      end
    endcase
    return res;
  endfunction

endpackage

[design/mbd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/mbd_front.sv]
// Front end: accepts parent pixels, tracks column and row, drives the line buffer.
// Depends on mbd_pkg; feeds the line buffer RAM and the quad queue.
module mbd_front #(
  parameter int MAX_DIM = mbd_pkg::MAX_DIM_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     clear,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [mbd_pkg::PIX_W-1:0]                in_pixel,
  input  logic [$clog2(MAX_DIM)-1:0]               wm1,
  input  logic [$clog2(MAX_DIM)-1:0]               hm1,
  input  logic [mbd_pkg::QC_W-1:0]                 q_count,
  output logic                                     stage_valid,
  output mbd_pkg::stage_t                          stage,
  output logic                                     ram_we,
  output logic [((MAX_DIM/2 > 1) ? $clog2(MAX_DIM/2) : 1)-1:0] ram_waddr,
  output logic [2*mbd_pkg::PIX_W-1:0]              ram_wdata,
  output logic                                     ram_re,
  output logic [((MAX_DIM/2 > 1) ? $clog2(MAX_DIM/2) : 1)-1:0] ram_raddr
);
  import mbd_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int PAIRS = MAX_DIM / 2;
  localparam int PA_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] prev_r;
  logic             stage_valid_r, stage_valid_nxt;
  stage_t           stage_r;

  logic             w1, h1, emit, accept;
  logic [CNT_W-1:0] last_c, last_r;
  logic [QC_W:0]    occ;
  logic [PIX_W-1:0] left;

  always_comb begin
    w1     = (wm1 == '0);
    h1     = (hm1 == '0);
    last_c = w1 ? '0 : (wm1[0] ? wm1 : wm1 - CNT_W'(1));
    last_r = h1 ? '0 : (hm1[0] ? hm1 : hm1 - CNT_W'(1));
    // count the word in the RAM stage as already queued
    occ      = {1'b0, q_count} + (QC_W+1)'(stage_valid_r);
    in_stall = (occ >= (QC_W+1)'(QUEUE_DEPTH));
    accept   = in_valid && !in_stall;
    emit     = (w1 || col_r[0]) && (h1 || row_r[0]);
    left     = w1 ? in_pixel : prev_r;
  end

  // Line buffer holds column pairs of the even row: {odd column, even column}
  always_comb begin
    ram_we    = accept && !h1 && !row_r[0] && (w1 || col_r[0]);
    ram_waddr = PA_W'(col_r >> 1);
    ram_wdata = {in_pixel, left};
    ram_re    = accept && emit && !h1;
    ram_raddr = PA_W'(col_r >> 1);
  end

  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    stage_valid_nxt = accept && emit;
    if (clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == wm1) begin
        col_nxt = '0;
        row_nxt = (row_r == hm1) ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_r       <= in_pixel;
      stage_r.h1   <= h1;
      stage_r.last <= (col_r == last_c) && (row_r == last_r);
      stage_r.left <= left;
      stage_r.px   <= in_pixel;
    end
  end

  assign stage_valid = stage_valid_r;
  assign stage       = stage_r;

endmodule

[design/mbd_queue.sv]
// Short FIFO of complete quads between the front end and the filter.
// Depends on mbd_pkg for the entry type and depth.
module mbd_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  mbd_pkg::q_entry_t        push_entry,
  input  logic                     pop,
  output mbd_pkg::q_entry_t        head,
  output logic [mbd_pkg::QC_W-1:0] count
);
  import mbd_pkg::*;

  q_entry_t         q_r [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QP_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QP_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = q_r[rd_ptr_r];
  assign count = count_r;

endmodule

[design/mbd_back.sv]
// Back end: filters the queued quad and holds the child pixel for the output side.
// Depends on mbd_pkg for the entry type and quad_filter.
module mbd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mbd_pkg::fmt_t             fmt,
  input  logic [mbd_pkg::QC_W-1:0]  q_count,
  input  mbd_pkg::q_entry_t         head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mbd_pkg::PIX_W-1:0] out_child_pixel,
  output logic                      out_level_done
);
  import mbd_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] child_r;
  logic             done_r;

  always_comb begin
    // advance when the output register is empty or being taken
    pop           = (q_count != '0) && (!out_valid_r || !out_stall);
    out_valid_nxt = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      child_r <= quad_filter(fmt, head.tl, head.tr, head.bl, head.br);
      done_r  <= head.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_child_pixel = child_r;
  assign out_level_done  = done_r;

endmodule

[design/mipmap_box_downsampler.sv]
// Top level of the 2x2 box-filter mip downsampler: config registers and glue.
// Depends on mbd_pkg, mbd_front, mbd_ram, mbd_queue and mbd_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in_     | input     | in_valid / in_stall   | in_source_pixel[31:0]
//   out_    | output    | out_valid / out_stall | out_child_pixel[31:0], out_level_done
//   cfg_    | input     | cfg_we                | cfg_index[1:0], cfg_data[11:0]
//
// Sustained rate is one parent pixel per cycle while in_stall is low; the word that
// closes a quad passes the stage word and registered line buffer read, the queue
// write, then the output register before its child pixel appears.
// Reset (rst_n low, synchronous) clears counters, the queue and the output valid;
// the line buffer needs no clearing since every read follows a write in the level.
// out_stall backs up into a four-word quad queue; in_stall rises only when that
// queue and the RAM stage together are full, and falls after one free output cycle.
module mipmap_box_downsampler #(
  parameter int MAX_DIM = mbd_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mbd_pkg::PIX_W-1:0]      in_source_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mbd_pkg::PIX_W-1:0]      out_child_pixel,
  output logic                           out_level_done,
  input  logic                           cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]      cfg_data
);
  import mbd_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int PAIRS = MAX_DIM / 2;
  localparam int PA_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  // Dimensions are held as (effective size - 1), clamped to 1..MAX_DIM
  fmt_t             fmt_r;
  logic [CNT_W-1:0] wm1_r;
  logic [CNT_W-1:0] hm1_r;
  logic [CNT_W-1:0] dim_m1;
  logic             cfg_clear;

  stage_t           stage;
  logic             stage_valid;
  logic             ram_we, ram_re;
  logic [PA_W-1:0]  ram_waddr, ram_raddr;
  logic [2*PIX_W-1:0] ram_wdata, ram_rdata;
  q_entry_t         push_entry, head;
  logic [QC_W-1:0]  q_count;
  logic             pop;

  always_comb begin
    if (cfg_data == '0) begin
      dim_m1 = '0;
    end else if (32'(cfg_data) > MAX_DIM) begin
      dim_m1 = CNT_W'(MAX_DIM - 1);
    end else begin
      dim_m1 = CNT_W'(cfg_data - CFG_W'(1));
    end
    // any write to a defined register restarts the level
    cfg_clear = cfg_we && (cfg_index == CFG_FORMAT || cfg_index == CFG_WIDTH ||
                           cfg_index == CFG_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_ARGB8888;
      wm1_r <= '0;
      hm1_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT: fmt_r <= fmt_t'(cfg_data[FMT_W-1:0]);
        CFG_WIDTH:  wm1_r <= dim_m1;
        CFG_HEIGHT: hm1_r <= dim_m1;
        default:    ;
      endcase
    end
  end

  mbd_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (cfg_clear),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel    (in_source_pixel),
    .wm1         (wm1_r),
    .hm1         (hm1_r),
    .q_count     (q_count),
    .stage_valid (stage_valid),
    .stage       (stage),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  // Line buffer: one word per column pair of the even row
  mbd_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (PAIRS)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Join the RAM read with the stage word; a one-row level reuses the bottom pair
  always_comb begin
    push_entry.tl   = stage.h1 ? stage.left : ram_rdata[PIX_W-1:0];
    push_entry.tr   = stage.h1 ? stage.px : ram_rdata[2*PIX_W-1:PIX_W];
    push_entry.bl   = stage.left;
    push_entry.br   = stage.px;
    push_entry.last = stage.last;
  end

  mbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (stage_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .count      (q_count)
  );

  mbd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fmt             (fmt_r),
    .q_count         (q_count),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_child_pixel (out_child_pixel),
    .out_level_done  (out_level_done)
  );

endmodule

[design/mbd_checker.sv]
// Port-level checks for the mip box downsampler, bound to the top level.
// Depends on mbd_pkg for format codes and register indexes.
module mbd_port_checks (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [mbd_pkg::PIX_W-1:0]     in_source_pixel,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mbd_pkg::PIX_W-1:0]     out_child_pixel,
  input logic                          out_level_done,
  input logic                          cfg_we,
  input logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [mbd_pkg::CFG_W-1:0]     cfg_data
);
  import mbd_pkg::*;

  logic [FMT_W-1:0] fmt_r;
  logic             narrow16, narrow8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_ARGB8888;
    end else if (cfg_we && cfg_index == CFG_FORMAT) begin
      fmt_r <= cfg_data[FMT_W-1:0];
    end
  end

  assign narrow16 = (fmt_r == FMT_R5G6B5) || (fmt_r == FMT_A4R4G4B4) ||
                    (fmt_r == FMT_A1R5G5B5);
  assign narrow8  = (fmt_r == FMT_L8);

  // Reset leaves an empty pipeline that takes input at once
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // One free output cycle drains enough of the queue to take the next word
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(!out_stall) |-> !in_stall)
    else $error("input stalled although the output side was free");

  // Narrow formats come out zero-extended
  a_zero_extend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (narrow16 || narrow8) |->
      out_child_pixel[31:16] == '0 && (!narrow8 || out_child_pixel[15:8] == '0))
    else $error("child pixel not zero-extended for narrow format");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_child_pixel) &&
      $stable(out_level_done))
    else $error("stalled output word changed");

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_source_pixel))
    else $error("stalled input word changed");

endmodule

bind mipmap_box_downsampler mbd_port_checks u_mbd_port_checks (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_source_pixel (in_source_pixel),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_child_pixel (out_child_pixel),
  .out_level_done  (out_level_done),
  .cfg_we          (cfg_we),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data)
);
